/* sv/paxos_acceptor_macros.svh */
// ---------------------------------------------------------------------------
// paxos acceptor assertion macros
// shared concurrent assertion forms, clocked on clk, off during reset
// ---------------------------------------------------------------------------
`ifndef PAXOS_ACCEPTOR_MACROS_SVH
`define PAXOS_ACCEPTOR_MACROS_SVH

// property that holds at every edge out of reset
`define PAXA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition at one edge implies a consequence at the next
`define PAXA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/paxa_pkg.sv */
// ---------------------------------------------------------------------------
// paxa_pkg
// types and constants shared by the paxos acceptor front, queue and back
// ---------------------------------------------------------------------------
package paxa_pkg;

	// field widths
	localparam int OP_W     = 2;
	localparam int INST_W   = 10;
	localparam int ROUND_W  = 32;
	localparam int NODE_W   = 16;
	localparam int VALUE_W  = 32;
	localparam int FAULT_W  = 2;

	// decided value store
	localparam int INSTANCE_DEPTH = 1024;
	localparam int ADDR_W         = $clog2(INSTANCE_DEPTH);

	// queue between front and back, power of two
	localparam int Q_DEPTH = 2;
	localparam int QPTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

	// message operation codes
	typedef enum logic [OP_W-1:0] {
		OP_PREPARE = 2'd0,
		OP_ACCEPT  = 2'd1,
		OP_DECIDE  = 2'd2,
		OP_COMMIT  = 2'd3
	} op_t;

	// message class after the front decoder
	typedef enum logic [2:0] {
		CLS_PREPARE = 3'd0,
		CLS_ACCEPT  = 3'd1,
		CLS_DECIDE  = 3'd2,
		CLS_COMMIT  = 3'd3,
		CLS_RANGE   = 3'd4
	} cls_t;

	// fault codes
	typedef enum logic [FAULT_W-1:0] {
		FAULT_NONE     = 2'd0,
		FAULT_MISMATCH = 2'd1,
		FAULT_AHEAD    = 2'd2,
		FAULT_RANGE    = 2'd3
	} fault_t;

	// classified message word held in the queue
	typedef struct packed {
		cls_t               cls;
		logic [INST_W-1:0]  inst;
		logic [ROUND_W-1:0] round;
		logic [NODE_W-1:0]  node;
		logic [VALUE_W-1:0] value;
	} qword_t;

	// queue head toward the back
	typedef struct packed {
		logic   valid;
		qword_t word;
	} qhead_t;

	// result word
	typedef struct packed {
		logic               accepted;
		logic               old_instance;
		logic [ROUND_W-1:0] reply_round;
		logic [NODE_W-1:0]  reply_node;
		logic [VALUE_W-1:0] reply_value;
		logic               commit_valid;
		logic [INST_W-1:0]  commit_instance;
		logic [VALUE_W-1:0] commit_value;
		fault_t             fault;
	} res_t;

endpackage

/* sv/paxa_queue.sv */
// ---------------------------------------------------------------------------
// paxa_queue
// short fifo of classified message words between front and back
// ---------------------------------------------------------------------------
`include "paxos_acceptor_macros.svh"

module paxa_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  paxa_pkg::qword_t push_word,
	input  logic            pop,
	output logic            full,
	output paxa_pkg::qhead_t head
);
	import paxa_pkg::*;

	qword_t              mem_q [Q_DEPTH];
	logic [QPTR_W-1:0]   wptr_q;
	logic [QPTR_W-1:0]   rptr_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic                do_pop;

	assign full       = (cnt_q == QCNT_W'(Q_DEPTH));
	assign head.valid = (cnt_q != '0);
	assign head.word  = mem_q[rptr_q];
	assign do_pop     = pop && head.valid;

	// storage
	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wptr_q] <= push_word;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push && !full) begin
				wptr_q <= wptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rptr_q <= rptr_q + QPTR_W'(1);
			end
			case ({push && !full, do_pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`PAXA_ASSERT(a_q_no_overflow, !(push && full), "push into full queue")
	`PAXA_ASSERT(a_q_count_bound, cnt_q <= QCNT_W'(Q_DEPTH), "queue count beyond depth")
	`PAXA_ASSERT_NEXT(a_q_pop_nonempty, pop && !push && cnt_q == QCNT_W'(1), !head.valid, "queue not empty after last pop")

endmodule

/* sv/paxa_front.sv */
// ---------------------------------------------------------------------------
// paxa_front
// input handshake and message classification into the queue
// ---------------------------------------------------------------------------
module paxa_front (
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [paxa_pkg::OP_W-1:0]     operation,
	input  logic [paxa_pkg::INST_W-1:0]   instance_req,
	input  logic [paxa_pkg::ROUND_W-1:0]  prop_round,
	input  logic [paxa_pkg::NODE_W-1:0]   prop_node,
	input  logic [paxa_pkg::VALUE_W-1:0]  value,
	input  logic                          q_full,
	input  logic                          clearing,
	output logic                          push,
	output paxa_pkg::qword_t              push_word
);
	import paxa_pkg::*;

	logic out_of_range;

	// hold off while the queue is full or the store is being cleared
	assign in_stall = q_full || clearing;
	assign push     = in_valid && !in_stall;

	// instance beyond the store
	assign out_of_range = ({1'b0, instance_req} >= (INST_W + 1)'(INSTANCE_DEPTH));

	// operation decoder
	always_comb begin
		push_word.inst  = instance_req;
		push_word.round = prop_round;
		push_word.node  = prop_node;
		push_word.value = value;
		if (out_of_range) begin
			push_word.cls = CLS_RANGE;
		end else begin
			unique case (op_t'(operation))
				OP_PREPARE: push_word.cls = CLS_PREPARE;
				OP_ACCEPT:  push_word.cls = CLS_ACCEPT;
				OP_DECIDE:  push_word.cls = CLS_DECIDE;
				OP_COMMIT:  push_word.cls = CLS_COMMIT;
				default:    push_word.cls = CLS_RANGE;
			endcase
		end
	end

endmodule

/* sv/paxa_back.sv */
// ---------------------------------------------------------------------------
// paxa_back
// acceptor state, decided value store and result register
// ---------------------------------------------------------------------------
`include "paxos_acceptor_macros.svh"

module paxa_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [paxa_pkg::NODE_W-1:0]  node_id,
	input  paxa_pkg::qhead_t             head,
	output logic                         pop,
	output logic                         clearing,
	output logic                         out_valid,
	input  logic                         out_stall,
	output paxa_pkg::res_t               res
);
	import paxa_pkg::*;

	// round state
	logic [ROUND_W-1:0] promised_round_q;
	logic [NODE_W-1:0]  promised_node_q;
	logic [ROUND_W-1:0] accepted_round_q;
	logic [NODE_W-1:0]  accepted_node_q;
	logic [VALUE_W-1:0] accepted_value_q;
	logic [INST_W-1:0]  highest_q;

	// store and its clearing pass
	logic [VALUE_W-1:0] store_q [INSTANCE_DEPTH];
	logic [ADDR_W:0]    clr_q;
	logic [VALUE_W-1:0] rd_s2;

	// result register
	logic               out_valid_q;
	res_t               res_s2;
	logic               use_rd_s2;

	// execute signals
	qword_t             w;
	logic               fire;
	logic               above_promise;
	logic               equal_promise;
	logic               inst_old;
	logic               inst_next;
	logic               do_install;
	logic [VALUE_W-1:0] install_value;
	logic               do_promise;
	logic               do_accept;
	logic               do_read;
	res_t               res_d;

	assign w        = head.word;
	assign clearing = !clr_q[ADDR_W];
	assign fire     = head.valid && !clearing && (!out_valid_q || !out_stall);
	assign pop      = fire;

	// proposal ordering by round then node
	assign above_promise = {w.round, w.node} > {promised_round_q, promised_node_q};
	assign equal_promise = {w.round, w.node} == {promised_round_q, promised_node_q};
	assign inst_old      = (w.inst <= highest_q);
	assign inst_next     = ({1'b0, w.inst} == ({1'b0, highest_q} + (INST_W + 1)'(1)));

	// message execution
	always_comb begin
		res_d         = '0;
		do_install    = 1'b0;
		install_value = w.value;
		do_promise    = 1'b0;
		do_accept     = 1'b0;
		do_read       = 1'b0;
		case (w.cls)
			CLS_PREPARE: begin
				if (inst_old) begin
					res_d.old_instance = 1'b1;
					do_read            = 1'b1;
				end else if (above_promise) begin
					do_promise        = 1'b1;
					res_d.accepted    = 1'b1;
					res_d.reply_round = accepted_round_q;
					res_d.reply_node  = accepted_node_q;
					res_d.reply_value = accepted_value_q;
				end
			end
			CLS_ACCEPT: begin
				if (above_promise || equal_promise) begin
					do_accept      = 1'b1;
					res_d.accepted = 1'b1;
				end
			end
			CLS_DECIDE: begin
				if (inst_next) begin
					if (w.value == accepted_value_q) begin
						do_install    = 1'b1;
						install_value = accepted_value_q;
					end else begin
						res_d.fault = FAULT_MISMATCH;
					end
				end else if (!inst_old) begin
					res_d.fault = FAULT_AHEAD;
				end
			end
			CLS_COMMIT: begin
				if (!inst_old) begin
					do_install = 1'b1;
				end
			end
			default: begin
				res_d.fault = FAULT_RANGE;
			end
		endcase
		if (do_install) begin
			res_d.commit_valid    = 1'b1;
			res_d.commit_instance = w.inst;
			res_d.commit_value    = install_value;
		end
	end

	// round state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			promised_round_q <= '0;
			promised_node_q  <= '0;
			accepted_round_q <= '0;
			accepted_node_q  <= '0;
			accepted_value_q <= '0;
			highest_q        <= '0;
		end else if (fire) begin
			if (do_install) begin
				highest_q        <= w.inst;
				promised_round_q <= '0;
				promised_node_q  <= node_id;
				accepted_round_q <= '0;
				accepted_node_q  <= node_id;
				accepted_value_q <= '0;
			end else if (do_promise) begin
				promised_round_q <= w.round;
				promised_node_q  <= w.node;
			end else if (do_accept) begin
				accepted_round_q <= w.round;
				accepted_node_q  <= w.node;
				accepted_value_q <= w.value;
			end
		end
	end

	// clearing pass over the store after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (clearing) begin
			clr_q <= clr_q + (ADDR_W + 1)'(1);
		end
	end

	// store write port
	always_ff @(posedge clk) begin
		if (clearing) begin
			store_q[clr_q[ADDR_W-1:0]] <= '0;
		end else if (fire && do_install) begin
			store_q[w.inst[ADDR_W-1:0]] <= install_value;
		end
	end

	// store read port, held while the result waits
	always_ff @(posedge clk) begin
		if (fire && do_read) begin
			rd_s2 <= store_q[w.inst[ADDR_W-1:0]];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2    <= res_d;
			use_rd_s2 <= do_read;
		end
	end

	// stored value replaces the reply value on an old instance
	always_comb begin
		res = res_s2;
		if (use_rd_s2) begin
			res.reply_value = rd_s2;
		end
	end

	assign out_valid = out_valid_q;

	`PAXA_ASSERT(a_b_no_fire_clearing, !(clearing && fire), "item executed during clearing pass")
	`PAXA_ASSERT_NEXT(a_b_install_highest, fire && do_install, highest_q == $past(w.inst), "highest instance not set by commit")
	`PAXA_ASSERT_NEXT(a_b_install_reset, fire && do_install, accepted_value_q == '0 && promised_round_q == '0, "round state not reset by commit")
	`PAXA_ASSERT(a_b_commit_no_fault, !(out_valid_q && res_s2.commit_valid && res_s2.fault != FAULT_NONE), "commit with fault")

endmodule

/* sv/paxos_acceptor.sv */
// throughput while out_stall is low and no clearing pass runs: one message per cycle;
// the back part executes one queued word per cycle; a two-entry queue parts the input
// from the back, the result register parts the output; reset: state clears at once,
// then a clearing pass zeroes the decided value store while in_stall stays high;
// configuration writes are taken throughout
// ---------------------------------------------------------------------------
// paxos_acceptor
// single-decree-per-instance paxos acceptor with decided value store
// ---------------------------------------------------------------------------
module paxos_acceptor (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [paxa_pkg::NODE_W-1:0]   cfg_data,
	// message input
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [paxa_pkg::OP_W-1:0]     operation,
	input  logic [paxa_pkg::INST_W-1:0]   instance_req,
	input  logic [paxa_pkg::ROUND_W-1:0]  prop_round,
	input  logic [paxa_pkg::NODE_W-1:0]   prop_node,
	input  logic [paxa_pkg::VALUE_W-1:0]  value,
	// result output
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          accepted,
	output logic                          old_instance,
	output logic [paxa_pkg::ROUND_W-1:0]  reply_round,
	output logic [paxa_pkg::NODE_W-1:0]   reply_node,
	output logic [paxa_pkg::VALUE_W-1:0]  reply_value,
	output logic                          commit_valid,
	output logic [paxa_pkg::INST_W-1:0]   commit_instance,
	output logic [paxa_pkg::VALUE_W-1:0]  commit_value,
	output logic [paxa_pkg::FAULT_W-1:0]  fault
);
	import paxa_pkg::*;

	logic [NODE_W-1:0] node_id_q;
	logic              q_full;
	logic              clearing;
	logic              push;
	qword_t            push_word;
	logic              pop;
	qhead_t            head;
	res_t              res;

	// node id register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_id_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			node_id_q <= cfg_data;
		end
	end

	// front: handshake and classification
	paxa_front u_front (
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.instance_req (instance_req),
		.prop_round   (prop_round),
		.prop_node    (prop_node),
		.value        (value),
		.q_full       (q_full),
		.clearing     (clearing),
		.push         (push),
		.push_word    (push_word)
	);

	// queue between front and back
	paxa_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.pop       (pop),
		.full      (q_full),
		.head      (head)
	);

	// back: acceptor state and store
	paxa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.node_id   (node_id_q),
		.head      (head),
		.pop       (pop),
		.clearing  (clearing),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res)
	);

	// result fields
	assign accepted        = res.accepted;
	assign old_instance    = res.old_instance;
	assign reply_round     = res.reply_round;
	assign reply_node      = res.reply_node;
	assign reply_value     = res.reply_value;
	assign commit_valid    = res.commit_valid;
	assign commit_instance = res.commit_instance;
	assign commit_value    = res.commit_value;
	assign fault           = res.fault;

endmodule

/* tb/paxos_acceptor_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// paxos_acceptor_tb
// drives prepare, accept, decide and commit words into the acceptor and checks
// every result word against a cycle-free predictor of the acceptor state;
// a short table of directed words comes first, then random protocol rounds
// under three idling mixes, a long output hold-off and a full drain
// ---------------------------------------------------------------------------
module paxos_acceptor_tb;
	import paxa_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int N_DIRECTED  = 22;

	typedef struct packed {
		op_t                op;
		logic [INST_W-1:0]  inst;
		logic [ROUND_W-1:0] round;
		logic [NODE_W-1:0]  node;
		logic [VALUE_W-1:0] value;
	} msg_t;

	typedef struct packed {
		msg_t msg;
		logic typed;
		res_t want;
	} dir_row_t;

	localparam res_t NO_REPLY = '{fault: FAULT_NONE, default: '0};

	// directed words; rows with typed set carry a hand-written result
	localparam dir_row_t DIRECTED [N_DIRECTED] = '{
		// prepare of instance 0 right after reset is an old instance
		'{'{OP_PREPARE, 10'd0, 32'd0, 16'd0, 32'd0}, 1'b1,
			'{old_instance: 1'b1, fault: FAULT_NONE, default: '0}},
		// decide far ahead of the highest decided instance
		'{'{OP_DECIDE, 10'd7, 32'd0, 16'd0, 32'd0}, 1'b1,
			'{fault: FAULT_AHEAD, default: '0}},
		// decide of next instance with a value that was never accepted
		'{'{OP_DECIDE, 10'd1, 32'd0, 16'd0, 32'd5}, 1'b1,
			'{fault: FAULT_MISMATCH, default: '0}},
		// prepare equal to the promise is rejected
		'{'{OP_PREPARE, 10'd1, 32'd0, 16'd0, 32'd0}, 1'b1, NO_REPLY},
		'{'{OP_ACCEPT, 10'd1, 32'd0, 16'd0, 32'hffff_ffff}, 1'b0, NO_REPLY},
		'{'{OP_PREPARE, 10'd1, 32'd0, 16'd1, 32'd0}, 1'b0, NO_REPLY},
		'{'{OP_ACCEPT, 10'd1, 32'd0, 16'd0, 32'd1}, 1'b0, NO_REPLY},
		'{'{OP_PREPARE, 10'd1, 32'hffff_ffff, 16'hffff, 32'd0}, 1'b0, NO_REPLY},
		'{'{OP_PREPARE, 10'd1, 32'hffff_ffff, 16'hffff, 32'd0}, 1'b0, NO_REPLY},
		'{'{OP_ACCEPT, 10'd1, 32'hffff_ffff, 16'hffff, 32'ha5a5_a5a5}, 1'b0, NO_REPLY},
		'{'{OP_DECIDE, 10'd1, 32'd0, 16'd0, 32'ha5a5_a5a5}, 1'b0, NO_REPLY},
		// decide of a past instance is ignored
		'{'{OP_DECIDE, 10'd1, 32'd0, 16'd0, 32'ha5a5_a5a5}, 1'b1, NO_REPLY},
		'{'{OP_PREPARE, 10'd1, 32'd0, 16'd0, 32'd0}, 1'b0, NO_REPLY},
		'{'{OP_COMMIT, 10'd3, 32'd0, 16'd0, 32'd0}, 1'b0, NO_REPLY},
		// commit of a past instance is ignored
		'{'{OP_COMMIT, 10'd2, 32'd0, 16'd0, 32'h1234_5678}, 1'b1, NO_REPLY},
		// skipped instance reads back empty
		'{'{OP_PREPARE, 10'd2, 32'd0, 16'd0, 32'd0}, 1'b1,
			'{old_instance: 1'b1, fault: FAULT_NONE, default: '0}},
		'{'{OP_PREPARE, 10'd4, 32'd1, 16'd0, 32'd0}, 1'b0, NO_REPLY},
		'{'{OP_ACCEPT, 10'd4, 32'd1, 16'd0, 32'h5a5a_5a5a}, 1'b0, NO_REPLY},
		'{'{OP_DECIDE, 10'd4, 32'd0, 16'd0, 32'd0}, 1'b0, NO_REPLY},
		'{'{OP_DECIDE, 10'd4, 32'd0, 16'd0, 32'h5a5a_5a5a}, 1'b0, NO_REPLY},
		'{'{OP_ACCEPT, 10'd5, 32'd0, 16'hfffe, 32'd1}, 1'b0, NO_REPLY},
		// decide of the empty value with nothing accepted
		'{'{OP_DECIDE, 10'd5, 32'd0, 16'd0, 32'd0}, 1'b0, NO_REPLY}
	};

	logic                clk;
	logic                arst_n          = 1'b0;
	logic                cfg_valid       = 1'b0;
	logic                cfg_ready;
	logic [NODE_W-1:0]   cfg_data        = '0;
	logic                in_valid        = 1'b0;
	logic                in_stall;
	logic [OP_W-1:0]     operation       = '0;
	logic [INST_W-1:0]   instance_req    = '0;
	logic [ROUND_W-1:0]  prop_round      = '0;
	logic [NODE_W-1:0]   prop_node       = '0;
	logic [VALUE_W-1:0]  value           = '0;
	logic                out_valid;
	logic                out_stall       = 1'b0;
	logic                accepted;
	logic                old_instance;
	logic [ROUND_W-1:0]  reply_round;
	logic [NODE_W-1:0]   reply_node;
	logic [VALUE_W-1:0]  reply_value;
	logic                commit_valid;
	logic [INST_W-1:0]   commit_instance;
	logic [VALUE_W-1:0]  commit_value;
	logic [FAULT_W-1:0]  fault;

	// predicted acceptor state
	logic [NODE_W-1:0]   node_id_q     = '0;
	logic [ROUND_W-1:0]  promise_round = '0;
	logic [NODE_W-1:0]   promise_node  = '0;
	logic [ROUND_W-1:0]  taken_round   = '0;
	logic [NODE_W-1:0]   taken_node    = '0;
	logic [VALUE_W-1:0]  taken_value   = '0;
	logic [INST_W-1:0]   top_inst      = '0;
	logic [VALUE_W-1:0]  decided_store [INSTANCE_DEPTH] = '{default: '0};

	res_t replies_due [$];

	int send_idle_pct  = 0;
	int recv_idle_pct  = 0;
	int hold_req       = 0;
	int hold_done      = 0;
	int hold_left      = 0;
	int words_sent     = 0;
	int results_seen   = 0;
	int commits_seen   = 0;
	int mismatches     = 0;

	paxos_acceptor dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.operation       (operation),
		.instance_req    (instance_req),
		.prop_round      (prop_round),
		.prop_node       (prop_node),
		.value           (value),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.accepted        (accepted),
		.old_instance    (old_instance),
		.reply_round     (reply_round),
		.reply_node      (reply_node),
		.reply_value     (reply_value),
		.commit_valid    (commit_valid),
		.commit_instance (commit_instance),
		.commit_value    (commit_value),
		.fault           (fault)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("paxos_acceptor_tb: timeout after %0d cycles", CYCLE_LIMIT);
		$display("paxos_acceptor_tb: done, errors");
		$finish;
	end

	task automatic note_mismatch(string msg);
		$display("paxos_acceptor_tb: result %0d: %s", results_seen, msg);
		mismatches++;
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			note_mismatch($sformatf("%s got %h want %h", name, got, want));
	endtask

	// decided value lands in the store and the round state starts over
	function automatic res_t install_decided(logic [INST_W-1:0] inst, logic [VALUE_W-1:0] val);
		res_t r;
		r = NO_REPLY;
		decided_store[inst] = val;
		top_inst = inst;
		promise_round = '0;
		promise_node = node_id_q;
		taken_round = '0;
		taken_node = node_id_q;
		taken_value = '0;
		r.commit_valid = 1'b1;
		r.commit_instance = inst;
		r.commit_value = val;
		return r;
	endfunction

	// result of one message word, updating the predicted state
	function automatic res_t acceptor_reply(msg_t m);
		res_t r;
		logic [INST_W:0] next_inst;
		r = NO_REPLY;
		next_inst = {1'b0, top_inst} + 1'b1;
		if (int'(m.inst) >= INSTANCE_DEPTH) begin
			r.fault = FAULT_RANGE;
			return r;
		end
		case (m.op)
			OP_PREPARE: begin
				if (m.inst <= top_inst) begin
					r.old_instance = 1'b1;
					r.reply_value = decided_store[m.inst];
				end else if ({m.round, m.node} > {promise_round, promise_node}) begin
					promise_round = m.round;
					promise_node = m.node;
					r.accepted = 1'b1;
					r.reply_round = taken_round;
					r.reply_node = taken_node;
					r.reply_value = taken_value;
				end
			end
			OP_ACCEPT: begin
				if ({m.round, m.node} >= {promise_round, promise_node}) begin
					taken_round = m.round;
					taken_node = m.node;
					taken_value = m.value;
					r.accepted = 1'b1;
				end
			end
			OP_DECIDE: begin
				if ({1'b0, m.inst} == next_inst) begin
					if (m.value == taken_value)
						r = install_decided(m.inst, taken_value);
					else
						r.fault = FAULT_MISMATCH;
				end else if (m.inst > top_inst) begin
					r.fault = FAULT_AHEAD;
				end
			end
			default: begin
				if (m.inst > top_inst)
					r = install_decided(m.inst, m.value);
			end
		endcase
		return r;
	endfunction

	// offer one word, hold it until taken, then queue its expected result
	task automatic send_msg(msg_t m, logic typed, res_t want);
		res_t pred;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		operation    <= m.op;
		instance_req <= m.inst;
		prop_round   <= m.round;
		prop_node    <= m.node;
		value        <= m.value;
		do @(posedge clk); while (in_stall);
		pred = acceptor_reply(m);
		if (typed)
			pred = want;
		replies_due.insert(replies_due.size(), pred);
		words_sent++;
	endtask

	// sender pause until every result is back and the block is quiet
	task automatic drain();
		in_valid <= 1'b0;
		while (replies_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_node_id(logic [NODE_W-1:0] id);
		cfg_valid <= 1'b1;
		cfg_data  <= id;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		node_id_q = id;
	endtask

	// mostly well-formed rounds on the next instance, plus past, ahead and noise words
	task automatic run_random(int count);
		int left;
		int pick;
		int ahead;
		msg_t m;
		logic [INST_W-1:0] next_inst;
		logic [VALUE_W-1:0] offered;
		left = count;
		while (left > 0) begin
			pick = $urandom_range(0, 99);
			next_inst = top_inst + 1'b1;
			m.inst = next_inst;
			m.node = 16'($urandom);
			m.value = $urandom;
			m.round = promise_round + 32'($urandom_range(0, 2));
			if (pick < 50) begin
				// prepare, accept, maybe a decide with one flipped bit, then decide or commit
				m.op = OP_PREPARE;
				send_msg(m, 1'b0, NO_REPLY);
				m.op = OP_ACCEPT;
				offered = ($urandom_range(0, 9) == 0) ? '0 : VALUE_W'($urandom);
				m.value = offered;
				send_msg(m, 1'b0, NO_REPLY);
				left -= 3;
				if ($urandom_range(0, 4) == 0) begin
					m.op = OP_DECIDE;
					m.value = offered ^ (32'd1 << $urandom_range(0, 31));
					send_msg(m, 1'b0, NO_REPLY);
					left--;
				end
				if ($urandom_range(0, 3) == 0) begin
					m.op = OP_COMMIT;
					m.inst = next_inst + 10'($urandom_range(0, 2));
					m.value = $urandom;
				end else begin
					m.op = OP_DECIDE;
					m.value = offered;
				end
				send_msg(m, 1'b0, NO_REPLY);
			end else if (pick < 70) begin
				// single prepare or accept close to the promise
				m.op = $urandom_range(0, 1) ? OP_ACCEPT : OP_PREPARE;
				m.round = promise_round + 32'($urandom_range(0, 2)) - 32'd1;
				m.node = promise_node + 16'($urandom_range(0, 2)) - 16'd1;
				send_msg(m, 1'b0, NO_REPLY);
				left--;
			end else if (pick < 85) begin
				// words on decided instances, or decides ahead
				m.op = op_t'($urandom_range(0, 3));
				if (m.op == OP_ACCEPT) begin
					ahead = int'(top_inst) + 2 + $urandom_range(0, 40);
					m.op = OP_DECIDE;
					m.inst = (ahead > INSTANCE_DEPTH - 1) ? INST_W'(INSTANCE_DEPTH - 1)
						: INST_W'(ahead);
				end else begin
					m.inst = INST_W'($urandom_range(0, top_inst));
				end
				send_msg(m, 1'b0, NO_REPLY);
				left--;
			end else begin
				// noise; commits kept from jumping far ahead
				m.op = op_t'($urandom_range(0, 3));
				m.inst = INST_W'($urandom);
				m.round = $urandom;
				if (m.op == OP_COMMIT && int'(m.inst) > int'(top_inst) + 3)
					m.inst = INST_W'($urandom_range(0, top_inst));
				send_msg(m, 1'b0, NO_REPLY);
				left--;
			end
		end
	endtask

	// output side: random stall, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_req != hold_done) begin
			hold_done = hold_req;
			hold_left = 80;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// compare every taken result word with the oldest expectation
	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (replies_due.size() == 0) begin
				note_mismatch("result word with nothing expected");
			end else begin
				want = replies_due.pop_front();
				check_field("accepted", 32'(accepted), 32'(want.accepted));
				check_field("old_instance", 32'(old_instance), 32'(want.old_instance));
				check_field("reply_round", reply_round, want.reply_round);
				check_field("reply_node", 32'(reply_node), 32'(want.reply_node));
				check_field("reply_value", reply_value, want.reply_value);
				check_field("commit_valid", 32'(commit_valid), 32'(want.commit_valid));
				check_field("commit_instance", 32'(commit_instance),
					32'(want.commit_instance));
				check_field("commit_value", commit_value, want.commit_value);
				check_field("fault", 32'(fault), 32'(want.fault));
			end
			if (commit_valid)
				commits_seen++;
			results_seen++;
		end
	end

	// stimulus
	initial begin : stimulus
		msg_t m;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed table, no idling; node id at its top value
		write_node_id(16'hffff);
		for (int i = 0; i < N_DIRECTED; i++)
			send_msg(DIRECTED[i].msg, DIRECTED[i].typed, DIRECTED[i].want);
		drain();

		// sender idles lightly, receiver heavily; drain halfway through
		write_node_id(16'h0000);
		send_idle_pct = 27;
		recv_idle_pct = 77;
		run_random(190);
		drain();
		run_random(190);
		drain();

		// the other way round
		write_node_id(16'($urandom_range(1, 16'hfffe)));
		send_idle_pct = 77;
		recv_idle_pct = 27;
		run_random(380);
		drain();

		// no idling, with one long output hold-off to back the block up
		write_node_id(16'($urandom));
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req++;
		run_random(340);

		// top instance, then everything is past
		m.op = OP_COMMIT;
		m.inst = INST_W'(INSTANCE_DEPTH - 1);
		m.round = $urandom;
		m.node = 16'($urandom);
		m.value = $urandom;
		send_msg(m, 1'b0, NO_REPLY);
		m.op = OP_DECIDE;
		send_msg(m, 1'b0, NO_REPLY);
		m.op = OP_PREPARE;
		send_msg(m, 1'b0, NO_REPLY);
		m.inst = INST_W'($urandom);
		send_msg(m, 1'b0, NO_REPLY);
		m.op = OP_COMMIT;
		send_msg(m, 1'b0, NO_REPLY);

		drain();
		repeat (8) @(posedge clk);
		if (replies_due.size() != 0)
			note_mismatch($sformatf("%0d results never arrived", replies_due.size()));
		$display("paxos_acceptor_tb: %0d words sent, %0d results checked, %0d commits",
			words_sent, results_seen, commits_seen);
		$display("paxos_acceptor_tb: highest instance %0d, %0d mismatches", top_inst,
			mismatches);
		if (mismatches == 0)
			$display("paxos_acceptor_tb: done, clean");
		else
			$display("paxos_acceptor_tb: done, errors");
		$finish;
	end

endmodule
